// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on an explicit clock and active-low reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// concurrent check on the block clock and reset
`define ASSERT_ALWAYS(label, prop, msg) \
    `ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ===== design/pdsc_pkg.sv =====
package pdsc_pkg;

    localparam int MAX_SEGMENTS_DEFAULT = 16;

    localparam int CHAR_W        = 8;
    localparam int SKIP_MASK_W   = 16;
    localparam int SEG_COUNT_W   = 5;
    localparam int M_TDATA_W     = 24;

    localparam logic [CHAR_W-1:0] CHAR_SEP = 8'd47;
    localparam logic [CHAR_W-1:0] CHAR_DOT = 8'd46;
    localparam logic [CHAR_W-1:0] CHAR_END = 8'd0;

    typedef struct packed {
        logic [SEG_COUNT_W-1:0] segment_count;
        logic [SKIP_MASK_W-1:0] skip_mask;
        logic                   path_ok;
    } result_t;

endpackage

// ===== design/pdsc_in_stage.sv =====
module pdsc_in_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [pdsc_pkg::CHAR_W-1:0] s_tdata,
    input  logic                        advance,
    output logic                        in_valid,
    output logic [pdsc_pkg::CHAR_W-1:0] in_char
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [pdsc_pkg::CHAR_W-1:0] char_reg;
    logic                        take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            char_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_char  = char_reg;

endmodule

// ===== design/pdsc_core.sv =====
module pdsc_core #(
    parameter int MAX_SEGMENTS = pdsc_pkg::MAX_SEGMENTS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [pdsc_pkg::CHAR_W-1:0] in_char,
    output logic                        is_end,
    output pdsc_pkg::result_t           result
);

    localparam int IW = $clog2(MAX_SEGMENTS + 1);

    logic [1:0]              len_reg,  len_next;
    logic                    fdot_reg, fdot_next;
    logic                    sdot_reg, sdot_next;
    logic [IW-1:0]           idx_reg,  idx_next;
    logic [MAX_SEGMENTS-1:0] skip_reg, skip_next;
    logic                    err_reg,  err_next;

    logic [MAX_SEGMENTS-1:0] idx_bit;
    logic [MAX_SEGMENTS-1:0] below;
    logic [MAX_SEGMENTS-1:0] open_segs;
    logic [MAX_SEGMENTS-1:0] open_rev;
    logic [MAX_SEGMENTS-1:0] low_rev;
    logic [MAX_SEGMENTS-1:0] last_open;
    logic                    is_dotdot;
    logic                    close_skip;
    logic                    close_err;
    logic [MAX_SEGMENTS-1:0] skip_closed;
    logic [IW-1:0]           idx_closed;
    logic                    is_dot;
    logic                    do_close;
    logic                    err_fin;
    logic [MAX_SEGMENTS-1:0] skip_fin;
    logic [IW-1:0]           idx_fin;
    logic [pdsc_pkg::SKIP_MASK_W-1:0] mask_out;
    logic [pdsc_pkg::SEG_COUNT_W-1:0] count_out;

    assign is_end = (in_char == pdsc_pkg::CHAR_END);
    assign is_dot = (in_char == pdsc_pkg::CHAR_DOT);

    // one-hot of the open segment's slot, and a mask of all slots before it
    assign idx_bit = {{(MAX_SEGMENTS-1){1'b0}}, 1'b1} << idx_reg;
    assign below   = idx_bit - {{(MAX_SEGMENTS-1){1'b0}}, 1'b1};
    assign open_segs = ~skip_reg & below;

    // most recent unskipped segment: reverse, isolate lowest one, reverse back
    for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_rev
        assign open_rev[i]  = open_segs[MAX_SEGMENTS-1-i];
        assign last_open[i] = low_rev[MAX_SEGMENTS-1-i];
    end
    assign low_rev = open_rev & (~open_rev + {{(MAX_SEGMENTS-1){1'b0}}, 1'b1});

    assign is_dotdot  = (len_reg == 2'd2) && fdot_reg && sdot_reg;
    assign close_skip = (len_reg == 2'd0) || (fdot_reg && ((len_reg == 2'd1) || is_dotdot));
    assign close_err  = is_dotdot && (open_segs == '0);

    always_comb begin
        skip_closed = skip_reg | (is_dotdot ? last_open : '0);
        if (close_skip) begin
            skip_closed = skip_closed | idx_bit;
        end else begin
            skip_closed = skip_closed & ~idx_bit;
        end
        idx_closed = close_err ? idx_reg : idx_reg + IW'(1);
    end

    // terminator view: the open segment closes only if it has bytes
    assign do_close = !err_reg && (len_reg != 2'd0);
    assign err_fin  = do_close ? close_err   : err_reg;
    assign skip_fin = do_close ? skip_closed : skip_reg;
    assign idx_fin  = do_close ? idx_closed  : idx_reg;

    if (MAX_SEGMENTS >= pdsc_pkg::SKIP_MASK_W) begin : g_mask_trunc
        assign mask_out = skip_fin[pdsc_pkg::SKIP_MASK_W-1:0];
    end else begin : g_mask_ext
        assign mask_out = {{(pdsc_pkg::SKIP_MASK_W-MAX_SEGMENTS){1'b0}}, skip_fin};
    end

    if (IW >= pdsc_pkg::SEG_COUNT_W) begin : g_cnt_trunc
        assign count_out = idx_fin[pdsc_pkg::SEG_COUNT_W-1:0];
    end else begin : g_cnt_ext
        assign count_out = {{(pdsc_pkg::SEG_COUNT_W-IW){1'b0}}, idx_fin};
    end

    always_comb begin
        result.path_ok       = !err_fin;
        result.skip_mask     = err_fin ? '0 : mask_out;
        result.segment_count = err_fin ? '0 : count_out;
    end

    always_comb begin
        len_next  = len_reg;
        fdot_next = fdot_reg;
        sdot_next = sdot_reg;
        idx_next  = idx_reg;
        skip_next = skip_reg;
        err_next  = err_reg;
        if (is_end) begin
            len_next  = 2'd0;
            fdot_next = 1'b0;
            sdot_next = 1'b0;
            idx_next  = '0;
            skip_next = '0;
            err_next  = 1'b0;
        end else if (err_reg) begin
            // drop bytes until the terminator
        end else if (idx_reg >= IW'(MAX_SEGMENTS)) begin
            err_next = 1'b1;
        end else if (in_char == pdsc_pkg::CHAR_SEP) begin
            skip_next = skip_closed;
            idx_next  = idx_closed;
            err_next  = close_err;
            len_next  = 2'd0;
            fdot_next = 1'b0;
            sdot_next = 1'b0;
        end else begin
            if (len_reg == 2'd0) begin
                fdot_next = is_dot;
            end else if (len_reg == 2'd1) begin
                sdot_next = is_dot;
            end
            if (len_reg != 2'd3) begin
                len_next = len_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= 2'd0;
            fdot_reg <= 1'b0;
            sdot_reg <= 1'b0;
            idx_reg  <= '0;
            skip_reg <= '0;
            err_reg  <= 1'b0;
        end else if (advance) begin
            len_reg  <= len_next;
            fdot_reg <= fdot_next;
            sdot_reg <= sdot_next;
            idx_reg  <= idx_next;
            skip_reg <= skip_next;
            err_reg  <= err_next;
        end
    end

endmodule

// ===== design/pdsc_out_stage.sv =====
module pdsc_out_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  pdsc_pkg::result_t              result,
    output logic                           out_free,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pdsc_pkg::M_TDATA_W-1:0] m_tdata
);

    logic              valid_reg;
    logic              valid_next;
    pdsc_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, res_reg.segment_count, res_reg.skip_mask, res_reg.path_ok};

endmodule

// ===== design/path_dot_segment_checker.sv =====
// Dot-segment checker for a path streamed one byte per transfer on s_tdata, ended by a
// zero byte. Bytes are taken one per cycle unless a terminator is held in the input
// register; each byte is classified from the input register in a single pass through the
// segment logic, and the terminator's result is loaded into the result register and shown
// on m_tdata. The only stall comes from the result register: when it holds an untaken
// result, a terminator waits in the input register. Bytes other than the terminator give
// no result. After a result the block takes the next path's bytes without idling.
`include "assert_macros.svh"

module path_dot_segment_checker #(
    parameter int MAX_SEGMENTS = pdsc_pkg::MAX_SEGMENTS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pdsc_pkg::CHAR_W-1:0]    s_tdata,  // [7:0] path_char
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pdsc_pkg::M_TDATA_W-1:0] m_tdata   // [0] path_ok, [16:1] skip_mask,
                                                     // [21:17] segment_count, [23:22] zero
);

    logic                        in_valid;
    logic [pdsc_pkg::CHAR_W-1:0] in_char;
    logic                        is_end;
    logic                        out_free;
    logic                        advance;
    logic                        out_load;
    pdsc_pkg::result_t           result;

    // a terminator moves on only when the result register can take it
    assign advance  = in_valid && (!is_end || out_free);
    assign out_load = advance && is_end;

    pdsc_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_valid (in_valid),
        .in_char  (in_char)
    );

    pdsc_core #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_char  (in_char),
        .is_end   (is_end),
        .result   (result)
    );

    pdsc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `ASSERT_ALWAYS(a_bad_path_zero, m_tvalid && !m_tdata[0] |-> m_tdata[21:1] == 21'd0, "invalid path result carries nonzero fields")
    `ASSERT_ALWAYS(a_mask_in_count, m_tvalid && m_tdata[0] |-> (m_tdata[16:1] >> m_tdata[21:17]) == 16'd0, "skip bit set at or above segment count")
    `ASSERT_ALWAYS(a_end_gives_result, out_load |=> m_tvalid, "terminator transfer did not produce a result")

endmodule

// ===== tb/path_dot_segment_checker_tb.sv =====
`timescale 1ns / 1ps

module path_dot_segment_checker_tb;
    import pdsc_pkg::*;

    localparam int RANDOM_CHARS    = 1300;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int STALL_LIMIT     = 2000;
    localparam int SEG_LIMIT       = MAX_SEGMENTS_DEFAULT;

    typedef enum int {
        SEG_EMPTY,
        SEG_DOT,
        SEG_DOTDOT,
        SEG_HIDDEN,
        SEG_DOTS,
        SEG_PLAIN,
        SEG_RAW
    } seg_kind_e;

    // expected classification of each path, built byte by byte
    class path_scoreboard;
        bit [1:0]    seg_len;
        bit          lead_dot;
        bit          second_dot;
        int unsigned seg_idx;
        bit [63:0]   skipped;
        bit          failed;
        result_t     verdict_q[$];
        int unsigned mismatches;
        int unsigned chars_seen;
        int unsigned paths_seen;
        int unsigned invalid_seen;
        int unsigned full_seen;

        function new();
            clear_path();
            mismatches   = 0;
            chars_seen   = 0;
            paths_seen   = 0;
            invalid_seen = 0;
            full_seen    = 0;
        endfunction

        function void clear_segment();
            seg_len    = 2'd0;
            lead_dot   = 1'b0;
            second_dot = 1'b0;
        endfunction

        function void clear_path();
            clear_segment();
            seg_idx = 0;
            skipped = '0;
            failed  = 1'b0;
        endfunction

        function void close_segment();
            bit [63:0] below;
            bit [63:0] open_bits;
            bit        drop;
            int        k;
            drop = 1'b0;
            if (seg_len == 2'd0) begin
                drop = 1'b1;
            end else if (!lead_dot) begin
                drop = 1'b0;
            end else if (seg_len == 2'd1) begin
                drop = 1'b1;
            end else if (seg_len == 2'd2 && second_dot) begin
                // parent reference cancels the newest segment still kept
                drop = 1'b1;
                below = (seg_idx == 0) ? 64'd0 : ((64'd1 << seg_idx) - 64'd1);
                open_bits = ~skipped & below;
                if (open_bits == 64'd0) begin
                    failed = 1'b1;
                end else begin
                    k = 63;
                    while (k > 0 && !open_bits[k]) k--;
                    skipped[k] = 1'b1;
                end
            end
            skipped[seg_idx % 64] = drop;
            if (!failed) seg_idx++;
            clear_segment();
        endfunction

        function void note_char(logic [CHAR_W-1:0] c);
            result_t want;
            chars_seen++;
            if (c == CHAR_END) begin
                if (!failed && seg_len != 2'd0) close_segment();
                want = '0;
                if (!failed) begin
                    want.path_ok       = 1'b1;
                    want.skip_mask     = skipped[SKIP_MASK_W-1:0];
                    want.segment_count = seg_idx[SEG_COUNT_W-1:0];
                    if (seg_idx == SEG_LIMIT) full_seen++;
                end else begin
                    invalid_seen++;
                end
                verdict_q.push_back(want);
                paths_seen++;
                clear_path();
                return;
            end
            if (failed) return;
            if (seg_idx >= SEG_LIMIT) begin
                failed = 1'b1;
                return;
            end
            if (c == CHAR_SEP) begin
                close_segment();
            end else begin
                if (seg_len == 2'd0) lead_dot = (c == CHAR_DOT);
                else if (seg_len == 2'd1) second_dot = (c == CHAR_DOT);
                if (seg_len != 2'd3) seg_len++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] word);
            result_t got;
            result_t want;
            got = result_t'(word[$bits(result_t)-1:0]);
            if (verdict_q.size() == 0) begin
                $error("result transfer with no path pending: m_tdata %h", word);
                mismatches++;
                return;
            end
            want = verdict_q.pop_front();
            if (got.path_ok !== want.path_ok) begin
                $error("path_ok: expected %0d, got %0d", want.path_ok, got.path_ok);
                mismatches++;
            end
            if (got.skip_mask !== want.skip_mask) begin
                $error("skip_mask: expected %h, got %h", want.skip_mask, got.skip_mask);
                mismatches++;
            end
            if (got.segment_count !== want.segment_count) begin
                $error("segment_count: expected %0d, got %0d",
                       want.segment_count, got.segment_count);
                mismatches++;
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [CHAR_W-1:0]     s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    path_scoreboard        sb;
    logic [CHAR_W-1:0]     path_buf[$];
    bit                    hold_off_req = 1'b0;
    bit                    hold_active  = 1'b0;

    always #1 aclk = ~aclk;

    path_dot_segment_checker uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CHAR_W-1:0] plain_char();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(1, 255)); while (c == CHAR_SEP || c == CHAR_DOT);
        return c;
    endfunction

    function automatic seg_kind_e pick_kind(bit long_path);
        int r;
        r = $urandom_range(0, 99);
        if (long_path) begin
            // no parent references so the path can get to the segment limit
            if (r < 10) return SEG_EMPTY;
            if (r < 20) return SEG_DOT;
            if (r < 30) return SEG_HIDDEN;
            return SEG_PLAIN;
        end
        if (r < 10) return SEG_EMPTY;
        if (r < 20) return SEG_DOT;
        if (r < 40) return SEG_DOTDOT;
        if (r < 50) return SEG_HIDDEN;
        if (r < 55) return SEG_DOTS;
        if (r < 85) return SEG_PLAIN;
        return SEG_RAW;
    endfunction

    function automatic void push_segment(seg_kind_e kind);
        logic [CHAR_W-1:0] c;
        case (kind)
            SEG_EMPTY: begin
            end
            SEG_DOT: begin
                path_buf.push_back(CHAR_DOT);
            end
            SEG_DOTDOT: begin
                path_buf.push_back(CHAR_DOT);
                path_buf.push_back(CHAR_DOT);
            end
            SEG_HIDDEN: begin
                path_buf.push_back(CHAR_DOT);
                repeat ($urandom_range(1, 3)) path_buf.push_back(plain_char());
            end
            SEG_DOTS: begin
                path_buf.push_back(CHAR_DOT);
                path_buf.push_back(CHAR_DOT);
                path_buf.push_back($urandom_range(0, 1) ? CHAR_DOT : plain_char());
            end
            SEG_PLAIN: begin
                repeat ($urandom_range(1, 5)) path_buf.push_back(plain_char());
            end
            default: begin
                repeat ($urandom_range(1, 4)) begin
                    do c = CHAR_W'($urandom_range(1, 255)); while (c == CHAR_SEP);
                    path_buf.push_back(c);
                end
            end
        endcase
    endfunction

    function automatic void build_random_path();
        int r;
        int nseg;
        bit long_path;
        r = $urandom_range(0, 99);
        path_buf.delete();
        if (r < 8) begin
            // noise: arbitrary nonzero bytes
            repeat ($urandom_range(1, 10)) path_buf.push_back(CHAR_W'($urandom_range(1, 255)));
        end else begin
            long_path = (r >= 90);
            nseg = long_path ? $urandom_range(SEG_LIMIT - 1, SEG_LIMIT + 2) : $urandom_range(0, 6);
            for (int i = 0; i < nseg; i++) begin
                if (i > 0) path_buf.push_back(CHAR_SEP);
                push_segment(pick_kind(long_path));
            end
            if (nseg > 0 && $urandom_range(0, 3) == 0) path_buf.push_back(CHAR_SEP);
        end
        path_buf.push_back(CHAR_END);
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c, input bit no_gaps);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_path(input bit no_gaps);
        foreach (path_buf[i]) send_char(path_buf[i], no_gaps);
    endtask

    task automatic idle_sender();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_char(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    initial begin : result_sink
        int gap;
        forever begin
            if (hold_off_req) begin
                hold_active = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                hold_active  = 1'b0;
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("FAIL path_dot_segment_checker");
        $finish;
    end

    initial begin : stimulus
        int bytes_sent;
        int paths_sent;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty path, unmatched parent, matched parent with trailing slash
        path_buf = '{CHAR_END};
        send_path(1'b0);
        path_buf = '{CHAR_DOT, CHAR_DOT, CHAR_END};
        send_path(1'b0);
        path_buf = '{"a", CHAR_SEP, CHAR_DOT, CHAR_DOT, CHAR_SEP, "b", CHAR_SEP, CHAR_END};
        send_path(1'b0);
        // hidden name, current dir, triple dot
        path_buf = '{CHAR_DOT, "a", CHAR_SEP, CHAR_DOT, CHAR_SEP,
                     CHAR_DOT, CHAR_DOT, CHAR_DOT, CHAR_END};
        send_path(1'b1);
        // high bytes and an empty segment in the middle
        path_buf = '{8'hff, 8'h80, CHAR_SEP, CHAR_SEP, 8'h01, CHAR_END};
        send_path(1'b0);

        bytes_sent = 0;
        paths_sent = 0;
        while (bytes_sent < RANDOM_CHARS) begin
            if (paths_sent == 25) begin
                // stall the result side and offer twelve short paths so that the input backs up
                idle_sender();
                hold_off_req = 1'b1;
                wait (hold_active);
                repeat (12) begin
                    path_buf = '{"x", CHAR_END};
                    send_path(1'b1);
                    bytes_sent += 2;
                end
            end
            if (paths_sent == 50) begin
                idle_sender();
                while (sb.pending() != 0) @(posedge aclk);
            end
            build_random_path();
            bytes_sent += path_buf.size();
            send_path($urandom_range(0, 3) == 0);
            paths_sent++;
        end

        idle_sender();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("checked %0d paths from %0d bytes: %0d invalid, %0d at the %0d-segment limit",
                 sb.paths_seen, sb.chars_seen, sb.invalid_seen, sb.full_seen, SEG_LIMIT);
        $display("random stalls on both sides, one long result hold-off, one full drain");
        if (sb.mismatches == 0) begin
            $display("PASS path_dot_segment_checker");
        end else begin
            $display("FAIL path_dot_segment_checker");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/pdsc_pkg.sv
design/pdsc_in_stage.sv
design/pdsc_core.sv
design/pdsc_out_stage.sv
design/path_dot_segment_checker.sv
tb/path_dot_segment_checker_tb.sv
